// ===== rtl/epsm_pkg.sv =====
package epsm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int AVG_SHIFT  = 4;
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int AVG_W      = SUM_W - AVG_SHIFT;
    localparam int LINES_W    = 16;
    localparam int LIMIT_W    = 32;
    localparam int PROD_W     = AVG_W + LINES_W;
    localparam int SPEED_W    = 32;
    localparam int MUL_CNT_W  = $clog2(LINES_W);

    // 2*pi*150 MHz in Q16.16, rounded
    localparam int K_W        = 46;
    localparam int K_CNT_W    = $clog2(K_W);
    localparam logic [K_W-1:0] SPEED_K = 46'd61766224843698;

    localparam logic [SAMPLE_W-1:0] SAT_PERIOD  = 16'hFFFF;
    localparam logic [LINES_W-1:0]  LINES_RESET = 16'd1024;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINES_PER_REV = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_LIMIT   = 1'b1;

    localparam logic KIND_CAPTURE = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

endpackage

// ===== rtl/encoder_period_speed_meter_core.sv =====
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   unit_event, capture_overflow, period[15:0]  kind
// m_axis    out  speed_value[31:0]                           overspeed_trip
// cfg       in   cfg_we, cfg_addr (0 lines_per_rev, 1 speed_limit), cfg_wdata
//
// Capture: at most one ring write, two (via ST_STORE2) when both unit_event and overflow are set.
// Compute: ST_SUM sums the ring, ST_MUL runs the bit-serial multiply, ST_DIV the
// restoring divider and ST_DONE loads the result; the next request is taken back
// in ST_IDLE. A zero divisor skips the divider. Reset at once clears the ring, the
// write index, state and output valid, and sets lines_per_rev to 1024 and speed_limit to all ones.
// A waiting result blocks only a finished compute, which holds until output is free.
module encoder_period_speed_meter_core
    import epsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // unit_event, capture_overflow, period
    input  logic                  s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // speed_value
    output logic                  m_axis_tuser,  // overspeed_trip
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE2,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [SAMPLE_W-1:0]   ring_reg [RING_DEPTH];
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [SUM_W-1:0]      acc_reg, acc_next;
    logic [PROD_W-1:0]     mcand_reg, mcand_next;
    logic [LINES_W-1:0]    mplier_reg, mplier_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [MUL_CNT_W-1:0]  mul_cnt_reg, mul_cnt_next;
    logic [PROD_W-1:0]     rem_reg, rem_next;
    logic [K_W-1:0]        q_reg, q_next;
    logic [K_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [LINES_W-1:0]    lines_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [SPEED_W-1:0]    m_data_reg, m_data_next;
    logic                  m_trip_reg, m_trip_next;

    logic                  ring_we;
    logic [SAMPLE_W-1:0]   ring_wdata;

    logic                  in_unit;
    logic                  in_ovf;
    logic [SAMPLE_W-1:0]   in_period;
    logic [PROD_W:0]       rem_shift;
    logic                  rem_ge;
    logic [PROD_W:0]       rem_diff;
    logic [SPEED_W-1:0]    speed;
    logic [IDX_W-1:0]      wr_idx_inc;

    assign in_unit   = s_axis_tdata[0];
    assign in_ovf    = s_axis_tdata[1];
    assign in_period = s_axis_tdata[SAMPLE_W+1:2];

    assign wr_idx_inc = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;

    // one quotient bit per cycle, dividend bits taken MSB first from the constant
    assign rem_shift = {rem_reg, SPEED_K[div_cnt_reg]};
    assign rem_ge    = rem_shift >= {1'b0, prod_reg};
    assign rem_diff  = rem_shift - {1'b0, prod_reg};

    assign speed = (|q_reg[K_W-1:SPEED_W]) ? '1 : q_reg[SPEED_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_trip_reg;

    always_comb
    begin
        state_next   = state_reg;
        wr_idx_next  = wr_idx_reg;
        rd_cnt_next  = rd_cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        prod_next    = prod_reg;
        mul_cnt_next = mul_cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg & ~m_axis_tready;
        m_data_next  = m_data_reg;
        m_trip_next  = m_trip_reg;
        ring_we      = 1'b0;
        ring_wdata   = SAT_PERIOD;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == KIND_COMPUTE)
                    begin
                        acc_next    = '0;
                        rd_cnt_next = '0;
                        state_next  = ST_SUM;
                    end
                    else if (in_ovf)
                    begin
                        ring_we     = 1'b1;
                        wr_idx_next = wr_idx_inc;
                        if (in_unit)
                            state_next = ST_STORE2;
                    end
                    else if (in_unit && in_period != SAT_PERIOD)
                    begin
                        ring_we     = 1'b1;
                        ring_wdata  = in_period;
                        wr_idx_next = wr_idx_inc;
                    end
                end
            end

            ST_STORE2:
            begin
                ring_we     = 1'b1;
                wr_idx_next = wr_idx_inc;
                state_next  = ST_IDLE;
            end

            ST_SUM:
            begin
                acc_next    = acc_reg + SUM_W'(ring_reg[rd_cnt_reg]);
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == IDX_W'(RING_DEPTH - 1))
                begin
                    mcand_next   = PROD_W'(acc_next[SUM_W-1:AVG_SHIFT]);
                    mplier_next  = lines_reg;
                    prod_next    = '0;
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (mplier_reg[0])
                    prod_next = prod_reg + mcand_reg;
                mcand_next   = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next  = {1'b0, mplier_reg[LINES_W-1:1]};
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MUL_CNT_W'(LINES_W - 1))
                begin
                    if (prod_next == '0)
                    begin
                        // zero divisor saturates
                        q_next     = '1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next     = '0;
                        q_next       = '0;
                        div_cnt_next = K_CNT_W'(K_W - 1);
                        state_next   = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next     = rem_ge ? rem_diff[PROD_W-1:0] : rem_shift[PROD_W-1:0];
                q_next       = {q_reg[K_W-2:0], rem_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    if (speed > limit_reg)
                    begin
                        m_data_next = '0;
                        m_trip_next = 1'b1;
                    end
                    else
                    begin
                        m_data_next = speed;
                        m_trip_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wr_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
            lines_reg   <= LINES_RESET;
            limit_reg   <= '1;
            for (int i = 0; i < RING_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_idx_reg  <= wr_idx_next;
            m_valid_reg <= m_valid_next;
            if (ring_we)
                ring_reg[wr_idx_reg] <= ring_wdata;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_LINES_PER_REV: lines_reg <= cfg_wdata[LINES_W-1:0];
                    CFG_SPEED_LIMIT:   limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cnt_reg  <= rd_cnt_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        prod_reg    <= prod_next;
        mul_cnt_reg <= mul_cnt_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        div_cnt_reg <= div_cnt_next;
        m_data_reg  <= m_data_next;
        m_trip_reg  <= m_trip_next;
    end

    a_trip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("trip result carries nonzero speed");

    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM || state_reg == ST_MUL || state_reg == ST_DIV
         || state_reg == ST_DONE) |=> $stable(wr_idx_reg))
        else $error("write index moved during compute");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_cnt_reg < K_CNT_W'(K_W))
        else $error("divider count out of range");

endmodule
